// ===== hdl/dppr_pkg.sv =====
// ----------------------------------------------------------------------------
// dppr_pkg
// Shared types, constants and helpers of the per-bank-pair refresh scheduler.
// ----------------------------------------------------------------------------
package dppr_pkg;

    localparam int NUM_PAIRS  = 8;
    localparam int PAIR_W     = $clog2(NUM_PAIRS);
    localparam int IN_PAIRS   = 8;
    localparam int TGT_W      = 3;
    localparam int TIME_W     = 64;
    localparam int CFG_ADDR_W = 2;
    localparam int CFG_DATA_W = 16;
    localparam int LIMIT_W    = 7;
    localparam int CREDIT_W   = 8;

    localparam logic [NUM_PAIRS-1:0] ALL_PAIRS = '1;

    // input command codes
    localparam logic [2:0] CMD_EVAL     = 3'd0;
    localparam logic [2:0] CMD_PAIR_REF = 3'd1;
    localparam logic [2:0] CMD_ALL_REF  = 3'd2;
    localparam logic [2:0] CMD_PD_ENTRY = 3'd3;
    localparam logic [2:0] CMD_SR_ENTRY = 3'd4;
    localparam logic [2:0] CMD_PD_EXIT  = 3'd5;

    // requested command codes
    localparam logic [1:0] NC_NONE      = 2'd0;
    localparam logic [1:0] NC_REFRESH   = 2'd1;
    localparam logic [1:0] NC_PRECHARGE = 2'd2;

    // register indexes
    localparam logic [CFG_ADDR_W-1:0] CFG_REFRESH_INTERVAL = 2'd0;
    localparam logic [CFG_ADDR_W-1:0] CFG_FIRST_TRIGGER    = 2'd1;
    localparam logic [CFG_ADDR_W-1:0] CFG_MAX_POSTPONED    = 2'd2;
    localparam logic [CFG_ADDR_W-1:0] CFG_MAX_PULLED_IN    = 2'd3;

    localparam logic [CFG_DATA_W-1:0] RST_REFRESH_INTERVAL = 16'd3900;

    typedef struct packed {
        logic [2:0]        command;
        logic [TIME_W-1:0] now;
        logic [7:0]        pair_idle;
        logic [7:0]        first_active;
        logic [7:0]        second_active;
    } t_in_word;

    typedef struct packed {
        logic [1:0]        next_command;
        logic [TGT_W-1:0]  target_pair;
        logic              target_second_bank;
        logic              block_pair;
        logic              wake_request;
        logic [TIME_W-1:0] next_trigger;
    } t_out_word;

    typedef struct packed {
        logic [NUM_PAIRS-1:0] pend_fixed;
        logic                 free_any;
        logic [PAIR_W-1:0]    free_low;
        logic [PAIR_W-1:0]    pend_low;
        logic [NUM_PAIRS-1:0] after_ref;
        logic [PAIR_W-1:0]    after_ref_low;
    } t_sel;

    function automatic logic [TIME_W-1:0] add_sat(input logic [TIME_W-1:0] a,
                                                   input logic [TIME_W-1:0] b);
        logic [TIME_W:0] s;
        s = {1'b0, a} + {1'b0, b};
        return s[TIME_W] ? '1 : s[TIME_W-1:0];
    endfunction

    function automatic logic [PAIR_W-1:0] lowest(input logic [NUM_PAIRS-1:0] m);
        logic [PAIR_W-1:0] r;
        r = '0;
        for (int i = NUM_PAIRS - 1; i >= 0; i--) begin
            if (m[i]) begin
                r = PAIR_W'(i);
            end
        end
        return r;
    endfunction

    function automatic logic [NUM_PAIRS-1:0] ext_mask(input logic [IN_PAIRS-1:0] v);
        logic [NUM_PAIRS-1:0] r;
        r = '0;
        for (int i = 0; i < NUM_PAIRS; i++) begin
            if (i < IN_PAIRS) begin
                r[i] = v[i % IN_PAIRS];
            end
        end
        return r;
    endfunction

    function automatic logic in_bit(input logic [IN_PAIRS-1:0] v,
                                    input logic [PAIR_W-1:0] p);
        logic r;
        r = 1'b0;
        for (int i = 0; i < NUM_PAIRS; i++) begin
            if (i < IN_PAIRS && p == PAIR_W'(i)) begin
                r = v[i % IN_PAIRS];
            end
        end
        return r;
    endfunction

endpackage

// ===== hdl/dppr_sel.sv =====
// ----------------------------------------------------------------------------
// dppr_sel
// Pair selection: pending mask refill, free mask and find-first encoders.
// ----------------------------------------------------------------------------
module dppr_sel (
    input  logic [dppr_pkg::NUM_PAIRS-1:0] i_pending,
    input  logic [dppr_pkg::IN_PAIRS-1:0]  i_idle,
    input  logic [dppr_pkg::PAIR_W-1:0]    i_chosen,
    output dppr_pkg::t_sel                 o_sel
);
    import dppr_pkg::*;

    logic [NUM_PAIRS-1:0] fixed;
    logic [NUM_PAIRS-1:0] free_mask;
    logic [NUM_PAIRS-1:0] cleared;
    logic [NUM_PAIRS-1:0] after_ref;

    always_comb begin
        fixed     = (i_pending == '0) ? ALL_PAIRS : i_pending;
        free_mask = ext_mask(i_idle) & fixed;
        cleared   = fixed & ~(NUM_PAIRS'(1) << i_chosen);
        after_ref = (cleared == '0) ? ALL_PAIRS : cleared;

        o_sel.pend_fixed    = fixed;
        o_sel.free_any      = |free_mask;
        o_sel.free_low      = lowest(free_mask);
        o_sel.pend_low      = lowest(fixed);
        o_sel.after_ref     = after_ref;
        o_sel.after_ref_low = lowest(after_ref);
    end

endmodule

// ===== hdl/dppr_sched.sv =====
// ----------------------------------------------------------------------------
// dppr_sched
// Scheduler state, configuration registers and per-word next-state logic.
// ----------------------------------------------------------------------------
module dppr_sched (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    input  logic                            i_cfg_we,
    input  logic [dppr_pkg::CFG_ADDR_W-1:0] i_cfg_addr,
    input  logic [dppr_pkg::CFG_DATA_W-1:0] i_cfg_data,
    input  logic                            i_go,
    input  dppr_pkg::t_in_word              i_word,
    output dppr_pkg::t_out_word             o_result
);
    import dppr_pkg::*;

    logic [CFG_DATA_W-1:0] r_interval;
    logic [LIMIT_W-1:0]    r_max_pp;
    logic [LIMIT_W-1:0]    r_max_pi;

    logic [TIME_W-1:0]    r_trig,    n_trig;
    logic                 r_pulled,  n_pulled;
    logic [CREDIT_W-1:0]  r_credit,  n_credit;
    logic                 r_asleep,  n_asleep;
    logic                 r_hold,    n_hold;
    logic [NUM_PAIRS-1:0] r_pending, n_pending;
    logic [PAIR_W-1:0]    r_chosen,  n_chosen;
    logic [1:0]           r_wcmd,    n_wcmd;
    logic                 r_wsecond, n_wsecond;
    logic [TGT_W-1:0]     r_target,  n_target;

    t_sel                 sel;
    logic [TIME_W-1:0]    intv;
    logic [TIME_W-1:0]    t_plus1;
    logic [TIME_W-1:0]    t_plus2;
    logic [TIME_W-1:0]    now_plus;
    logic                 step;
    logic                 pulled1;
    logic                 forced;
    logic                 busy;
    logic [PAIR_W-1:0]    pick;
    logic                 fa_bit;
    logic                 sa_bit;
    logic [CREDIT_W-1:0]  credit1;
    logic                 blk;
    logic                 wake;

    dppr_sel u_sel (
        .i_pending (r_pending),
        .i_idle    (i_word.pair_idle),
        .i_chosen  (r_chosen),
        .o_sel     (sel)
    );

    always_comb begin
        intv     = TIME_W'(r_interval);
        t_plus1  = add_sat(r_trig, intv);
        t_plus2  = add_sat(r_trig, {intv[TIME_W-2:0], 1'b0});
        now_plus = add_sat(i_word.now, intv);
        step     = (i_word.now >= t_plus1);
        pulled1  = step ? 1'b0 : r_pulled;
        forced   = (r_credit == {1'b0, r_max_pp});
        busy     = r_hold ? 1'b1 : ~sel.free_any;
        pick     = r_chosen;
        if (r_pulled && !step) begin
            pick = sel.free_low;
        end else if (!r_hold) begin
            pick = sel.free_any ? sel.free_low : sel.pend_low;
        end
        fa_bit  = in_bit(i_word.first_active, pick);
        sa_bit  = in_bit(i_word.second_active, pick);
        credit1 = r_pulled ? (r_credit - CREDIT_W'(1)) : r_credit;

        n_trig    = r_trig;
        n_pulled  = r_pulled;
        n_credit  = r_credit;
        n_asleep  = r_asleep;
        n_hold    = r_hold;
        n_pending = r_pending;
        n_chosen  = r_chosen;
        n_wcmd    = r_wcmd;
        n_wsecond = r_wsecond;
        n_target  = r_target;
        blk       = 1'b0;
        wake      = 1'b0;

        unique case (i_word.command)
            CMD_EVAL: begin
                n_wcmd = NC_NONE;
                if (i_word.now >= r_trig) begin
                    wake = 1'b1;
                    if (!r_asleep) begin
                        n_pending = sel.pend_fixed;
                        n_trig    = step ? t_plus1 : r_trig;
                        n_pulled  = pulled1;
                        if (!pulled1) begin
                            n_chosen = pick;
                            if (busy && !forced) begin
                                n_credit = r_credit + CREDIT_W'(1);
                                n_trig   = step ? t_plus2 : t_plus1;
                            end else begin
                                n_target  = TGT_W'(pick);
                                n_wcmd    = (fa_bit || sa_bit) ? NC_PRECHARGE : NC_REFRESH;
                                n_wsecond = ~fa_bit & sa_bit;
                                if (!fa_bit && !sa_bit && forced) begin
                                    blk    = 1'b1;
                                    n_hold = 1'b1;
                                end
                            end
                        end else if (!sel.free_any) begin
                            n_chosen = sel.pend_low;
                            n_pulled = 1'b0;
                            n_trig   = t_plus1;
                        end else begin
                            n_chosen  = pick;
                            n_target  = TGT_W'(pick);
                            n_wcmd    = (fa_bit || sa_bit) ? NC_PRECHARGE : NC_REFRESH;
                            n_wsecond = ~fa_bit & sa_bit;
                        end
                    end
                end
            end
            CMD_PAIR_REF: begin
                n_hold    = 1'b0;
                n_pending = sel.after_ref;
                n_chosen  = sel.after_ref_low;
                n_credit  = credit1;
                n_pulled  = 1'b1;
                if (credit1 == (CREDIT_W'(0) - {1'b0, r_max_pi})) begin
                    n_pulled = 1'b0;
                    n_trig   = t_plus1;
                end
            end
            CMD_ALL_REF: begin
                n_pulled  = 1'b0;
                n_trig    = now_plus;
                n_asleep  = 1'b0;
                n_pending = ALL_PAIRS;
                n_chosen  = '0;
                n_hold    = 1'b0;
            end
            CMD_PD_ENTRY: begin
                n_asleep = 1'b1;
            end
            CMD_SR_ENTRY: begin
                n_asleep = 1'b1;
                n_trig   = '1;
            end
            CMD_PD_EXIT: begin
                n_asleep = 1'b0;
            end
            default: begin
            end
        endcase

        o_result.next_command       = n_wcmd;
        o_result.target_pair        = n_target;
        o_result.target_second_bank = n_wsecond;
        o_result.block_pair         = blk;
        o_result.wake_request       = wake;
        o_result.next_trigger       = n_trig;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_interval <= RST_REFRESH_INTERVAL;
            r_max_pp   <= '0;
            r_max_pi   <= '0;
            r_trig     <= '0;
            r_pulled   <= 1'b0;
            r_credit   <= '0;
            r_asleep   <= 1'b0;
            r_hold     <= 1'b0;
            r_pending  <= ALL_PAIRS;
            r_chosen   <= '0;
            r_wcmd     <= NC_NONE;
            r_wsecond  <= 1'b0;
            r_target   <= '0;
        end else if (i_cfg_we) begin
            unique case (i_cfg_addr)
                CFG_REFRESH_INTERVAL: begin
                    r_interval <= i_cfg_data;
                end
                CFG_FIRST_TRIGGER: begin
                    r_trig <= TIME_W'(i_cfg_data);
                end
                CFG_MAX_POSTPONED: begin
                    r_max_pp <= i_cfg_data[LIMIT_W-1:0];
                end
                CFG_MAX_PULLED_IN: begin
                    r_max_pi <= i_cfg_data[LIMIT_W-1:0];
                end
                default: begin
                end
            endcase
        end else if (i_go) begin
            r_trig    <= n_trig;
            r_pulled  <= n_pulled;
            r_credit  <= n_credit;
            r_asleep  <= n_asleep;
            r_hold    <= n_hold;
            r_pending <= n_pending;
            r_chosen  <= n_chosen;
            r_wcmd    <= n_wcmd;
            r_wsecond <= n_wsecond;
            r_target  <= n_target;
        end
    end

endmodule

// ===== hdl/dram_per_two_bank_refresh_scheduler.sv =====
// ----------------------------------------------------------------------------
// dram_per_two_bank_refresh_scheduler
// Per-bank-pair refresh scheduler with postpone and pull-in credit.
// ----------------------------------------------------------------------------
// usage
//   input channel (i_in_valid / o_in_ready / i_in_data): one word per evaluate
//   tick or per command the controller has issued
//   output channel (o_out_valid / i_out_ready / o_out_data): exactly one
//   result word per input word, in order
//   config port (i_cfg_we / i_cfg_addr / i_cfg_data): single-cycle writes,
//   only while no word is in flight; writing the first trigger reloads the
//   trigger time
//   path: a word is held in the input register, is evaluated and lands in
//   the output register, from which its result is offered; while that
//   register is full and not taken, the word waits in the input register
//   throughput: one word per cycle while the receiver takes results; the
//   state update around the 64-bit trigger adders and compares is registered
//   reset: synchronous, active low; clears both stages and loads all
//   scheduler state to its initial values
//   stall: while the receiver holds i_out_ready low, the result holds and one
//   more word can still be taken into the input register
// ----------------------------------------------------------------------------
module dram_per_two_bank_refresh_scheduler (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    input  logic                            i_in_valid,
    output logic                            o_in_ready,
    input  dppr_pkg::t_in_word              i_in_data,
    output logic                            o_out_valid,
    input  logic                            i_out_ready,
    output dppr_pkg::t_out_word             o_out_data,
    input  logic                            i_cfg_we,
    input  logic [dppr_pkg::CFG_ADDR_W-1:0] i_cfg_addr,
    input  logic [dppr_pkg::CFG_DATA_W-1:0] i_cfg_data
);
    import dppr_pkg::*;

    logic      r_in_valid;
    t_in_word  r_in_data;
    logic      r_out_valid;
    t_out_word r_out_data;
    t_out_word result;
    logic      out_free;
    logic      go;

    assign out_free   = ~r_out_valid | i_out_ready;
    assign go         = r_in_valid & out_free;
    assign o_in_ready = ~r_in_valid | out_free;

    dppr_sched u_sched (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_cfg_we   (i_cfg_we),
        .i_cfg_addr (i_cfg_addr),
        .i_cfg_data (i_cfg_data),
        .i_go       (go),
        .i_word     (r_in_data),
        .o_result   (result)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid  <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            if (o_in_ready) begin
                r_in_valid <= i_in_valid;
            end
            if (out_free) begin
                r_out_valid <= go;
            end
        end
        if (i_in_valid && o_in_ready) begin
            r_in_data <= i_in_data;
        end
        if (go) begin
            r_out_data <= result;
        end
    end

    assign o_out_valid = r_out_valid;
    assign o_out_data  = r_out_data;

`ifndef SYNTH
    a_block_is_refresh: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && o_out_data.block_pair |->
            o_out_data.wake_request && o_out_data.next_command == NC_REFRESH)
        else $error("block without forced refresh");

    a_cmd_legal: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid |-> o_out_data.next_command == NC_NONE ||
            o_out_data.next_command == NC_REFRESH ||
            o_out_data.next_command == NC_PRECHARGE)
        else $error("illegal requested command");

    a_taken_goes_out: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_in_valid && out_free |=> o_out_valid)
        else $error("evaluated word lost");
`endif

endmodule

// ===== tb/sv/dppr_refresh_checker.sv =====
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// dppr_refresh_checker
// Watches both channels and the register port of the bank-pair refresh
// scheduler. It keeps its own copy of the scheduler state and settings,
// works out the request word that each accepted input word must produce,
// and compares every result word field by field with the oldest one waiting.
// ----------------------------------------------------------------------------
module dppr_refresh_checker (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    input  logic                            i_in_valid,
    input  logic                            i_in_ready,
    input  dppr_pkg::t_in_word              i_in_data,
    input  logic                            i_out_valid,
    input  logic                            i_out_ready,
    input  dppr_pkg::t_out_word             i_out_data,
    input  logic                            i_cfg_we,
    input  logic [dppr_pkg::CFG_ADDR_W-1:0] i_cfg_addr,
    input  logic [dppr_pkg::CFG_DATA_W-1:0] i_cfg_data,
    output int                              o_fail_count,
    output int                              o_outstanding
);
    import dppr_pkg::*;

    logic [15:0]          ival;
    logic [6:0]           post_limit;
    logic [6:0]           pull_limit;
    logic [63:0]          trigger_at;
    logic                 pulled_in;
    logic [7:0]           credit;
    logic                 asleep;
    logic                 hold_pick;
    logic [NUM_PAIRS-1:0] pending;
    logic [PAIR_W-1:0]    chosen;
    logic [TGT_W-1:0]     target;
    logic [1:0]           want_cmd;
    logic                 want_second;

    t_out_word            expected_requests[$];
    t_out_word            predicted;
    t_out_word            oldest;
    int                   fail_count = 0;

    assign o_fail_count = fail_count;

    function automatic logic [63:0] sat_add(input logic [63:0] a, input logic [63:0] b);
        logic [63:0] s;
        s = a + b;
        return (s < a) ? '1 : s;
    endfunction

    function automatic logic [PAIR_W-1:0] lowest_set(input logic [NUM_PAIRS-1:0] m);
        for (int p = 0; p < NUM_PAIRS; p++) begin
            if (m[p]) begin
                return PAIR_W'(p);
            end
        end
        return '0;
    endfunction

    task automatic reset_model();
        ival        = RST_REFRESH_INTERVAL;
        post_limit  = '0;
        pull_limit  = '0;
        trigger_at  = '0;
        pulled_in   = 1'b0;
        credit      = '0;
        asleep      = 1'b0;
        hold_pick   = 1'b0;
        pending     = ALL_PAIRS;
        chosen      = '0;
        target      = '0;
        want_cmd    = NC_NONE;
        want_second = 1'b0;
    endtask

    task automatic refill_pending();
        if (pending == '0) begin
            pending = ALL_PAIRS;
        end
    endtask

    // refresh the pair, or precharge its first open bank beforehand
    task automatic request_for(input logic [PAIR_W-1:0] pair, input logic [7:0] fa,
                               input logic [7:0] sa);
        want_cmd    = NC_REFRESH;
        want_second = 1'b0;
        target      = TGT_W'(pair);
        if (fa[pair]) begin
            want_cmd = NC_PRECHARGE;
        end else if (sa[pair]) begin
            want_cmd    = NC_PRECHARGE;
            want_second = 1'b1;
        end
    endtask

    task automatic predict_request(input t_in_word w, output t_out_word r);
        logic                 blk;
        logic                 wake;
        logic                 forced;
        logic                 busy;
        logic [NUM_PAIRS-1:0] free;
        blk  = 1'b0;
        wake = 1'b0;
        case (w.command)
            CMD_EVAL: begin
                want_cmd = NC_NONE;
                if (w.now >= trigger_at) begin
                    wake = 1'b1;
                    if (!asleep) begin
                        refill_pending();
                        if (w.now >= sat_add(trigger_at, ival)) begin
                            trigger_at = sat_add(trigger_at, ival);
                            pulled_in  = 1'b0;
                        end
                        free = NUM_PAIRS'(w.pair_idle) & pending;
                        if (!pulled_in) begin
                            forced = (int'($signed(credit)) == int'(post_limit));
                            busy   = 1'b1;
                            if (!hold_pick) begin
                                if (free != '0) begin
                                    busy   = 1'b0;
                                    chosen = lowest_set(free);
                                end else begin
                                    chosen = lowest_set(pending);
                                end
                            end
                            if (busy && !forced) begin
                                credit     = credit + 8'd1;
                                trigger_at = sat_add(trigger_at, ival);
                            end else begin
                                request_for(chosen, w.first_active, w.second_active);
                                if (want_cmd == NC_REFRESH && forced) begin
                                    blk       = 1'b1;
                                    hold_pick = 1'b1;
                                end
                            end
                        end else if (free == '0) begin
                            chosen     = lowest_set(pending);
                            pulled_in  = 1'b0;
                            trigger_at = sat_add(trigger_at, ival);
                        end else begin
                            chosen = lowest_set(free);
                            request_for(chosen, w.first_active, w.second_active);
                        end
                    end
                end
            end
            CMD_PAIR_REF: begin
                hold_pick = 1'b0;
                refill_pending();
                pending[chosen] = 1'b0;
                refill_pending();
                chosen = lowest_set(pending);
                if (pulled_in) begin
                    credit = credit - 8'd1;
                end else begin
                    pulled_in = 1'b1;
                end
                if (int'($signed(credit)) == -int'(pull_limit)) begin
                    pulled_in  = 1'b0;
                    trigger_at = sat_add(trigger_at, ival);
                end
            end
            CMD_ALL_REF: begin
                pulled_in  = 1'b0;
                trigger_at = sat_add(w.now, ival);
                asleep     = 1'b0;
                pending    = ALL_PAIRS;
                chosen     = '0;
                hold_pick  = 1'b0;
            end
            CMD_PD_ENTRY: begin
                asleep = 1'b1;
            end
            CMD_SR_ENTRY: begin
                asleep     = 1'b1;
                trigger_at = '1;
            end
            CMD_PD_EXIT: begin
                asleep = 1'b0;
            end
            default: begin
            end
        endcase
        r.next_command       = want_cmd;
        r.target_pair        = target;
        r.target_second_bank = want_second;
        r.block_pair         = blk;
        r.wake_request       = wake;
        r.next_trigger       = trigger_at;
    endtask

    task automatic check_field(input string name, input logic [63:0] want,
                               input logic [63:0] got);
        if (want !== got) begin
            $error("%s: expected %0h, actual %0h", name, want, got);
            fail_count++;
        end
    endtask

    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            reset_model();
            expected_requests.delete();
        end else begin
            if (i_cfg_we) begin
                case (i_cfg_addr)
                    CFG_REFRESH_INTERVAL: ival = i_cfg_data;
                    CFG_FIRST_TRIGGER:    trigger_at = 64'(i_cfg_data);
                    CFG_MAX_POSTPONED:    post_limit = i_cfg_data[6:0];
                    CFG_MAX_PULLED_IN:    pull_limit = i_cfg_data[6:0];
                    default: begin
                    end
                endcase
            end
            if (i_out_valid && i_out_ready) begin
                if (expected_requests.size() == 0) begin
                    $error("result word with no request word waiting: %0h", i_out_data);
                    fail_count++;
                end else begin
                    oldest = expected_requests.pop_front();
                    check_field("next_command", oldest.next_command, i_out_data.next_command);
                    check_field("target_pair", oldest.target_pair, i_out_data.target_pair);
                    check_field("target_second_bank", oldest.target_second_bank,
                                i_out_data.target_second_bank);
                    check_field("block_pair", oldest.block_pair, i_out_data.block_pair);
                    check_field("wake_request", oldest.wake_request, i_out_data.wake_request);
                    check_field("next_trigger", oldest.next_trigger, i_out_data.next_trigger);
                end
            end
            if (i_in_valid && i_in_ready) begin
                predict_request(i_in_data, predicted);
                expected_requests.insert(expected_requests.size(), predicted);
            end
        end
        o_outstanding <= expected_requests.size();
    end

endmodule

// ===== tb/sv/dram_per_two_bank_refresh_scheduler_tb.sv =====
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// dram_per_two_bank_refresh_scheduler_tb
// Drives the bank-pair refresh scheduler with a short directed sequence and
// then random traffic under several register settings, with random gaps on
// the input side and random back-pressure on the result side. A checker
// beside the block predicts and compares every result word.
// ----------------------------------------------------------------------------
module dram_per_two_bank_refresh_scheduler_tb;
    import dppr_pkg::*;

    localparam int         HALF_PERIOD   = 5;
    localparam int         LIMIT_CYCLES  = 400000;
    localparam int         SETTLE_CYCLES = 6;
    localparam int         NUM_PHASES    = 7;
    localparam int         PHASE_WORDS   = 170;
    localparam logic [2:0] CMD_OTHER     = 3'd6;
    localparam logic [2:0] CMD_SPARE     = 3'd7;

    logic                  clk       = 1'b0;
    logic                  rst_n     = 1'b0;
    logic                  in_valid  = 1'b0;
    t_in_word              in_data   = '0;
    logic                  in_ready;
    logic                  out_valid;
    logic                  out_ready = 1'b0;
    t_out_word             out_data;
    logic                  cfg_we    = 1'b0;
    logic [CFG_ADDR_W-1:0] cfg_addr  = '0;
    logic [CFG_DATA_W-1:0] cfg_data  = '0;
    int                    fail_count;
    int                    outstanding;
    int                    cycle_count = 0;

    logic [63:0]           clock_now    = '0;
    int                    cur_interval = 3900;
    int                    sender_run   = 0;
    bit                    sender_calm  = 1'b0;
    int                    ready_hold   = 0;
    int                    ready_run    = 0;
    bit                    ready_calm   = 1'b0;

    dram_per_two_bank_refresh_scheduler dut (
        .i_clk       (clk),
        .i_rst_n     (rst_n),
        .i_in_valid  (in_valid),
        .o_in_ready  (in_ready),
        .i_in_data   (in_data),
        .o_out_valid (out_valid),
        .i_out_ready (out_ready),
        .o_out_data  (out_data),
        .i_cfg_we    (cfg_we),
        .i_cfg_addr  (cfg_addr),
        .i_cfg_data  (cfg_data)
    );

    dppr_refresh_checker checker_i (
        .i_clk         (clk),
        .i_rst_n       (rst_n),
        .i_in_valid    (in_valid),
        .i_in_ready    (in_ready),
        .i_in_data     (in_data),
        .i_out_valid   (out_valid),
        .i_out_ready   (out_ready),
        .i_out_data    (out_data),
        .i_cfg_we      (cfg_we),
        .i_cfg_addr    (cfg_addr),
        .i_cfg_data    (cfg_data),
        .o_fail_count  (fail_count),
        .o_outstanding (outstanding)
    );

    always #HALF_PERIOD clk = ~clk;

    always @(posedge clk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count == LIMIT_CYCLES) begin
            $display("Test completed with failures");
            $finish;
        end
    end

    function automatic int gap_len();
        int r;
        r = $urandom_range(0, 99);
        if (r < 60) begin
            return 0;
        end
        if (r < 92) begin
            return $urandom_range(1, 3);
        end
        return $urandom_range(8, 40);
    endfunction

    // result side back-pressure
    always @(posedge clk) begin
        if (!rst_n) begin
            out_ready <= 1'b0;
            ready_hold = 0;
            ready_run  = 0;
        end else begin
            if (ready_run == 0) begin
                ready_calm = ($urandom_range(0, 3) == 0);
                ready_run  = $urandom_range(40, 200);
            end
            ready_run = ready_run - 1;
            if (ready_calm) begin
                out_ready <= 1'b1;
                ready_hold = 0;
            end else if (ready_hold > 0) begin
                ready_hold = ready_hold - 1;
            end else if (out_ready) begin
                out_ready <= 1'b0;
                ready_hold = gap_len();
            end else begin
                out_ready <= 1'b1;
                ready_hold = $urandom_range(0, 6);
            end
        end
    end

    function automatic t_in_word make_word(input logic [2:0] cmd, input logic [63:0] t,
                                           input logic [7:0] idle, input logic [7:0] fa,
                                           input logic [7:0] sa);
        t_in_word w;
        w.command       = cmd;
        w.now           = t;
        w.pair_idle     = idle;
        w.first_active  = fa;
        w.second_active = sa;
        return w;
    endfunction

    function automatic logic [7:0] idle_mask();
        int r;
        r = $urandom_range(0, 99);
        if (r < 30) begin
            return 8'h00;
        end
        if (r < 45) begin
            return 8'hFF;
        end
        return 8'($urandom);
    endfunction

    function automatic logic [7:0] open_mask();
        if ($urandom_range(0, 1) == 0) begin
            return 8'h00;
        end
        return 8'($urandom);
    endfunction

    function automatic logic [63:0] step_time();
        int r;
        r = $urandom_range(0, 9);
        if (r < 2) begin
            return 64'd0;
        end
        if (r < 7) begin
            return 64'($urandom_range(0, cur_interval / 2));
        end
        return 64'($urandom_range(cur_interval / 2, cur_interval * 2));
    endfunction

    task automatic send_word(input t_in_word w);
        int gap;
        if (sender_run == 0) begin
            sender_calm = ($urandom_range(0, 3) == 0);
            sender_run  = $urandom_range(30, 120);
        end
        sender_run = sender_run - 1;
        gap = sender_calm ? 0 : gap_len();
        if (gap > 0) begin
            in_valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        in_valid <= 1'b1;
        in_data  <= w;
        do begin
            @(posedge clk);
        end while (!in_ready);
    endtask

    task automatic drain();
        in_valid <= 1'b0;
        @(posedge clk);
        while (outstanding != 0) begin
            @(posedge clk);
        end
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    task automatic write_regs(input logic [15:0] ri, input logic [15:0] ft,
                              input logic [15:0] mp, input logic [15:0] mpi);
        cfg_we   <= 1'b1;
        cfg_addr <= CFG_REFRESH_INTERVAL;
        cfg_data <= ri;
        @(posedge clk);
        cfg_addr <= CFG_FIRST_TRIGGER;
        cfg_data <= ft;
        @(posedge clk);
        cfg_addr <= CFG_MAX_POSTPONED;
        cfg_data <= mp;
        @(posedge clk);
        cfg_addr <= CFG_MAX_PULLED_IN;
        cfg_data <= mpi;
        @(posedge clk);
        cfg_we <= 1'b0;
    endtask

    task automatic run_directed();
        // reset settings: trigger at zero, refresh forced at once
        send_word(make_word(CMD_EVAL, 64'd0, 8'hFF, 8'h00, 8'h00));
        send_word(make_word(CMD_EVAL, 64'd0, 8'h00, 8'hFF, 8'h00));
        send_word(make_word(CMD_EVAL, 64'd0, 8'h00, 8'h00, 8'hFF));
        send_word(make_word(CMD_EVAL, 64'd0, 8'h00, 8'h00, 8'h00));
        send_word(make_word(CMD_PAIR_REF, 64'd0, 8'h00, 8'h00, 8'h00));
        send_word(make_word(CMD_EVAL, 64'd100, 8'hFF, 8'h00, 8'h00));
        send_word(make_word(CMD_EVAL, 64'd3900, 8'h80, 8'h00, 8'h80));
        // run the pending mask empty so that it refills
        repeat (8) begin
            send_word(make_word(CMD_PAIR_REF, 64'd3900, 8'h00, 8'h00, 8'h00));
        end
        send_word(make_word(CMD_PD_ENTRY, 64'd8000, 8'h00, 8'h00, 8'h00));
        send_word(make_word(CMD_EVAL, 64'd8000, 8'hFF, 8'h00, 8'h00));
        send_word(make_word(CMD_PD_EXIT, 64'd8000, 8'h00, 8'h00, 8'h00));
        send_word(make_word(CMD_SR_ENTRY, 64'd9000, 8'h00, 8'h00, 8'h00));
        send_word(make_word(CMD_EVAL, '1, 8'hFF, 8'h00, 8'h00));
        // trigger saturates at the top of the time range
        send_word(make_word(CMD_ALL_REF, '1, 8'h00, 8'h00, 8'h00));
        send_word(make_word(CMD_EVAL, '1, 8'hFF, 8'hFF, 8'hFF));
        send_word(make_word(CMD_OTHER, '1, 8'hFF, 8'hFF, 8'hFF));
        send_word(make_word(CMD_SPARE, 64'd0, 8'h00, 8'h00, 8'h00));
        send_word(make_word(CMD_ALL_REF, 64'd0, 8'h00, 8'h00, 8'h00));
    endtask

    task automatic setup_phase(input int p);
        logic [15:0] ri;
        logic [15:0] ft;
        logic [15:0] mp;
        logic [15:0] mpi;
        case (p)
            0: begin ri = 16'd3900;  ft = 16'd0;     mp = 16'd0;  mpi = 16'd0;  end
            1: begin ri = 16'd1;     ft = 16'd65535; mp = 16'd64; mpi = 16'd64; end
            2: begin ri = 16'd65535; ft = 16'd0;     mp = 16'd0;  mpi = 16'd64; end
            3: begin ri = 16'd40;    ft = 16'd20;    mp = 16'd6;  mpi = 16'd3;  end
            4: begin ri = 16'd7;     ft = 16'd3;     mp = 16'd2;  mpi = 16'd64; end
            6: begin ri = 16'd2;     ft = 16'd0;     mp = 16'd64; mpi = 16'd0;  end
            default: begin
                ri  = 16'($urandom_range(1, 2000));
                ft  = 16'($urandom_range(0, 4 * ri));
                mp  = 16'($urandom_range(0, 64));
                mpi = 16'($urandom_range(0, 64));
            end
        endcase
        cur_interval = ri;
        clock_now    = '0;
        write_regs(ri, ft, mp, mpi);
    endtask

    task automatic run_phase(input int n_words);
        int sent;
        int choice;
        int len;
        sent = 0;
        while (sent < n_words) begin
            choice = $urandom_range(0, 99);
            if (choice < 55) begin
                clock_now = clock_now + step_time();
                send_word(make_word(CMD_EVAL, clock_now, idle_mask(), open_mask(), open_mask()));
                sent++;
                if ($urandom_range(0, 2) == 0) begin
                    send_word(make_word(CMD_PAIR_REF, clock_now, idle_mask(), open_mask(),
                                        open_mask()));
                    sent++;
                end
            end else if (choice < 68) begin
                // all pairs busy for a while: postpone credit builds up
                len = $urandom_range(3, 20);
                repeat (len) begin
                    clock_now = clock_now + 64'(cur_interval);
                    send_word(make_word(CMD_EVAL, clock_now, 8'h00, open_mask(), open_mask()));
                end
                sent += len;
            end else if (choice < 76) begin
                len = $urandom_range(1, 4);
                send_word(make_word(CMD_PD_ENTRY, clock_now, idle_mask(), open_mask(),
                                    open_mask()));
                repeat (len) begin
                    clock_now = clock_now + step_time();
                    send_word(make_word(CMD_EVAL, clock_now, idle_mask(), open_mask(),
                                        open_mask()));
                end
                send_word(make_word(CMD_PD_EXIT, clock_now, idle_mask(), open_mask(),
                                    open_mask()));
                sent += len + 2;
            end else if (choice < 80) begin
                len = $urandom_range(1, 3);
                send_word(make_word(CMD_SR_ENTRY, clock_now, idle_mask(), open_mask(),
                                    open_mask()));
                repeat (len) begin
                    clock_now = clock_now + step_time();
                    send_word(make_word(CMD_EVAL, clock_now, idle_mask(), open_mask(),
                                        open_mask()));
                end
                send_word(make_word(CMD_ALL_REF, clock_now, idle_mask(), open_mask(),
                                    open_mask()));
                sent += len + 2;
            end else if (choice < 86) begin
                send_word(make_word(CMD_ALL_REF, clock_now, idle_mask(), open_mask(),
                                    open_mask()));
                sent++;
            end else if (choice < 89) begin
                clock_now = {$urandom, $urandom};
                if ($urandom_range(0, 1) == 0) begin
                    clock_now = clock_now | 64'hFFFF_FFFF_FFFF_0000;
                end
                send_word(make_word(CMD_ALL_REF, clock_now, idle_mask(), open_mask(),
                                    open_mask()));
                sent++;
            end else if (choice < 98) begin
                send_word(make_word(3'($urandom_range(0, 6)), {$urandom, $urandom},
                                    8'($urandom), 8'($urandom), 8'($urandom)));
                sent++;
            end else begin
                drain();
            end
        end
    endtask

    initial begin
        repeat (2) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);
        run_directed();
        drain();
        for (int p = 0; p < NUM_PHASES; p++) begin
            setup_phase(p);
            run_phase(PHASE_WORDS);
            drain();
        end
        if (fail_count == 0) begin
            $display("Test completed successfully");
        end else begin
            $display("Test completed with failures");
        end
        $finish;
    end

endmodule

// ===== dram_per_two_bank_refresh_scheduler.f =====
hdl/dppr_pkg.sv
hdl/dppr_sel.sv
hdl/dppr_sched.sv
hdl/dram_per_two_bank_refresh_scheduler.sv
tb/sv/dppr_refresh_checker.sv
tb/sv/dram_per_two_bank_refresh_scheduler_tb.sv
